### src/config_text_tokenizer_top_defines.svh
// Assertion macros for the tokenizer RTL.
`ifndef CONFIG_TEXT_TOKENIZER_TOP_DEFINES_SVH
`define CONFIG_TEXT_TOKENIZER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define TOK_ASSERT(name, clock, rstn, prop) \
  name: assert property (@(posedge clock) disable iff (!rstn) prop) \
    else $error("tokenizer assertion failed");
`define TOK_ASSERT_NR(name, clock, prop) \
  name: assert property (@(posedge clock) prop) \
    else $error("tokenizer assertion failed");
`else
`define TOK_ASSERT(name, clock, rstn, prop)
`define TOK_ASSERT_NR(name, clock, prop)
`endif

`endif

### src/ctt_pkg.sv
// Types, constants and helpers for the text tokenizer.
package ctt_pkg;

  typedef enum logic [2:0] {
    MODE_SKIP    = 3'd0,
    MODE_COMMENT = 3'd1,
    MODE_WHITE   = 3'd2,
    MODE_WORD    = 3'd3,
    MODE_DOUBLE  = 3'd4,
    MODE_SINGLE  = 3'd5
  } mode_t;

  localparam logic KIND_APPEND = 1'b0;
  localparam logic KIND_END    = 1'b1;

  localparam logic [7:0] CH_NL   = 8'h0A;
  localparam logic [7:0] CH_DQ   = 8'h22;
  localparam logic [7:0] CH_SQ   = 8'h27;
  localparam logic [7:0] CH_HASH = 8'h23;

  localparam int MAX_RES    = 3;
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_BITS   = $clog2(FIFO_DEPTH);
  localparam int CNT_BITS   = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic        kind;
    logic [7:0]  ch;
    logic [15:0] line;
    logic        last;
  } tok_item_t;

  typedef struct packed {
    tok_item_t [MAX_RES-1:0] item;
    logic [1:0]              n;
    mode_t                   mode;
  } dec_res_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'h20) || (c inside {[8'h09:8'h0D]});
  endfunction

  function automatic tok_item_t mk_item(input logic kind, input logic [7:0] ch,
                                        input logic [15:0] line);
    tok_item_t t;
    t.kind = kind;
    t.ch   = ch;
    t.line = line;
    t.last = 1'b0;
    return t;
  endfunction

endpackage

### src/config_text_tokenizer_top.sv
// Top level of the configuration text tokenizer.
//
// Input channel: in_valid/in_ready carry one transaction per character,
// in_text_byte plus in_end_of_source (which ends any open token and
// returns to skip mode). Output channel: out_valid/out_ready carry one
// result per transaction: out_item_kind (append or token complete),
// out_token_char, out_line_number and out_last_of_run on the final result
// caused by one character.
// An accepted character is held in an input register, is decoded
// against the lexer mode, and its zero to three results enter a four-entry
// result queue, and the first result is presented from the queue's registers.
// Throughput is one character per cycle while each character yields at
// most one result and out_ready stays high; the single output port drains
// results one at a time, so a three-result newline can stall the input.
// The input register advances only when the queue has room for all the
// character's results, so a stalled receiver backs up into in_ready.
// Synchronous reset empties the queue and input register, sets skip mode
// and line one; no clearing pass is needed.
`include "config_text_tokenizer_top_defines.svh"
module config_text_tokenizer_top #(
  parameter int LINE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_text_byte,
  input  logic        in_end_of_source,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_item_kind,
  output logic [7:0]  out_token_char,
  output logic [15:0] out_line_number,
  output logic        out_last_of_run
);
  import ctt_pkg::*;

  logic                 stage_valid_r;
  logic [7:0]           stage_byte_r;
  logic                 stage_eos_r;
  mode_t                mode_r;
  logic [LINE_BITS-1:0] line_r;
  logic [LINE_BITS-1:0] line_nxt;
  dec_res_t             dec;
  tok_item_t            head;
  logic [CNT_BITS-1:0]  free;
  logic                 pop;
  logic                 advance;
  logic                 in_fire;

  ctt_decode #(.LINE_BITS(LINE_BITS)) u_decode (
    .mode          (mode_r),
    .line_cnt      (line_r),
    .text_byte     (stage_byte_r),
    .end_of_source (stage_eos_r),
    .res           (dec),
    .line_nxt      (line_nxt)
  );

  assign pop     = out_valid && out_ready;
  assign advance = stage_valid_r && ((free + CNT_BITS'(pop)) >= CNT_BITS'(dec.n));
  assign in_ready = !stage_valid_r || advance;
  assign in_fire  = in_valid && in_ready;

  ctt_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (advance ? dec.n : 2'd0),
    .push_item (dec.item),
    .pop       (pop),
    .head      (head),
    .not_empty (out_valid),
    .free      (free)
  );

  assign out_item_kind   = head.kind;
  assign out_token_char  = head.ch;
  assign out_line_number = head.line;
  assign out_last_of_run = head.last;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      stage_byte_r <= in_text_byte;
      stage_eos_r  <= in_end_of_source;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
      mode_r        <= MODE_SKIP;
      line_r        <= LINE_BITS'(1);
    end else begin
      if (in_fire) stage_valid_r <= 1'b1;
      else if (advance) stage_valid_r <= 1'b0;
      if (advance) begin
        mode_r <= dec.mode;
        line_r <= line_nxt;
      end
    end
  end

  `TOK_ASSERT(a_line_monotonic, clk, rst_n, advance |=> line_r >= $past(line_r))
  `TOK_ASSERT(a_eos_skip, clk, rst_n, advance && stage_eos_r |=> mode_r == MODE_SKIP)
  `TOK_ASSERT(a_stage_hold, clk, rst_n, stage_valid_r && !advance |=> stage_valid_r)
  `TOK_ASSERT(a_no_overflow, clk, rst_n, advance |-> free + CNT_BITS'(pop) >= CNT_BITS'(dec.n))

endmodule

### src/ctt_decode.sv
// Per-character decode: results, next mode and next line count.
module ctt_decode #(
  parameter int LINE_BITS = 16
) (
  input  ctt_pkg::mode_t       mode,
  input  logic [LINE_BITS-1:0] line_cnt,
  input  logic [7:0]           text_byte,
  input  logic                 end_of_source,
  output ctt_pkg::dec_res_t    res,
  output logic [LINE_BITS-1:0] line_nxt
);
  import ctt_pkg::*;

  logic [LINE_BITS-1:0] line_inc;
  logic [15:0]          ln_old;
  logic [15:0]          ln_new;
  logic                 nl;
  logic [7:0]           c;

  assign c        = text_byte;
  assign nl       = (c == CH_NL);
  assign line_inc = (&line_cnt) ? line_cnt : line_cnt + LINE_BITS'(1);
  assign ln_old   = 16'(line_cnt);
  assign ln_new   = 16'(line_inc);
  assign line_nxt = (!end_of_source && nl) ? line_inc : line_cnt;

  always_comb begin
    res.item = '0;
    res.n    = 2'd0;
    res.mode = mode;
    if (end_of_source) begin
      res.mode = MODE_SKIP;
      if (mode == MODE_WORD || mode == MODE_DOUBLE || mode == MODE_SINGLE) begin
        res.item[0] = mk_item(KIND_END, 8'h00, ln_old);
        res.n       = 2'd1;
      end
    end else begin
      case (mode)
        MODE_COMMENT: begin
          if (nl) res.mode = MODE_SKIP;
        end
        MODE_WORD: begin
          if (nl) begin
            res.item[0] = mk_item(KIND_END, 8'h00, ln_old);
            res.item[1] = mk_item(KIND_APPEND, CH_NL, ln_old);
            res.item[2] = mk_item(KIND_END, 8'h00, ln_old);
            res.n       = 2'd3;
            res.mode    = MODE_SKIP;
          end else if (is_blank(c)) begin
            res.item[0] = mk_item(KIND_END, 8'h00, ln_old);
            res.n       = 2'd1;
            res.mode    = MODE_WHITE;
          end else if (c == CH_DQ) begin
            res.mode = MODE_DOUBLE;
          end else if (c == CH_SQ) begin
            res.mode = MODE_SINGLE;
          end else if (c == CH_HASH) begin
            res.item[0] = mk_item(KIND_END, 8'h00, ln_old);
            res.n       = 2'd1;
            res.mode    = MODE_COMMENT;
          end else begin
            res.item[0] = mk_item(KIND_APPEND, c, ln_old);
            res.n       = 2'd1;
          end
        end
        MODE_DOUBLE, MODE_SINGLE: begin
          if (c == ((mode == MODE_DOUBLE) ? CH_DQ : CH_SQ)) begin
            res.mode = MODE_WORD;
          end else begin
            res.item[0] = mk_item(KIND_APPEND, c, nl ? ln_new : ln_old);
            res.n       = 2'd1;
          end
        end
        default: begin
          if (nl) begin
            res.mode = MODE_SKIP;
            if (mode == MODE_WHITE) begin
              res.item[0] = mk_item(KIND_APPEND, CH_NL, ln_old);
              res.item[1] = mk_item(KIND_END, 8'h00, ln_old);
              res.n       = 2'd2;
            end
          end else if (!is_blank(c)) begin
            if (c == CH_DQ) begin
              res.mode = MODE_DOUBLE;
            end else if (c == CH_SQ) begin
              res.mode = MODE_SINGLE;
            end else if (c == CH_HASH) begin
              res.mode = MODE_COMMENT;
            end else begin
              res.item[0] = mk_item(KIND_APPEND, c, ln_old);
              res.n       = 2'd1;
              res.mode    = MODE_WORD;
            end
          end
        end
      endcase
    end
    for (int i = 0; i < MAX_RES; i++) begin
      res.item[i].last = (2'(i) == res.n - 2'd1);
    end
  end

endmodule

### src/ctt_fifo.sv
// Result queue: takes up to three results a cycle, gives one.
module ctt_fifo (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [1:0]                           push_n,
  input  ctt_pkg::tok_item_t [ctt_pkg::MAX_RES-1:0] push_item,
  input  logic                                 pop,
  output ctt_pkg::tok_item_t                   head,
  output logic                                 not_empty,
  output logic [ctt_pkg::CNT_BITS-1:0]         free
);
  import ctt_pkg::*;

  tok_item_t [FIFO_DEPTH-1:0] mem_r;
  logic [PTR_BITS-1:0]        wptr_r;
  logic [PTR_BITS-1:0]        wptr_nxt;
  logic [PTR_BITS-1:0]        rptr_r;
  logic [PTR_BITS-1:0]        rptr_nxt;
  logic [CNT_BITS-1:0]        count_r;
  logic [CNT_BITS-1:0]        count_nxt;

  assign not_empty = (count_r != '0);
  assign head      = mem_r[rptr_r];
  assign free      = CNT_BITS'(FIFO_DEPTH) - count_r;
  assign wptr_nxt  = wptr_r + PTR_BITS'(push_n);
  assign rptr_nxt  = rptr_r + PTR_BITS'(pop);
  assign count_nxt = count_r + CNT_BITS'(push_n) - CNT_BITS'(pop);

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RES; i++) begin
      if (2'(i) < push_n) mem_r[wptr_r + PTR_BITS'(i)] <= push_item[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

endmodule
